// File: src/tvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_pkg: shared types and constants
// Field widths, register map and the queued request type of the
// tetrahedron volume block.
// ----------------------------------------------------------------------------
package tvs_pkg;

  localparam int CoordW = 16;
  localparam int EdgeW  = 17;
  localparam int VolW   = 49;
  localparam int ConstW = 24;
  localparam int SizeW  = 22;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  localparam logic [ConstW-1:0] InvVolReset = 24'd304535;

  // register index, taken from paddr[2]
  localparam logic RegInvVol = 1'b0;

  typedef struct packed {
    logic [8:0][EdgeW-1:0]  edges;
    logic [2:0][CoordW-1:0] cen;
  } tvs_item_t;

endpackage

// File: src/tvs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_front: request intake
// Forms the edge vectors and the floored centroid of each request and
// holds them in a register for the queue.
// ----------------------------------------------------------------------------
module tvs_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [11:0][tvs_pkg::CoordW-1:0]         node_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output tvs_pkg::tvs_item_t                       out_item_o
);
  import tvs_pkg::*;

  logic      valid_q, valid_d;
  tvs_item_t item_q, item_d;
  logic signed [CoordW+1:0] sum;

  always_comb begin
    item_d = '0;
    sum    = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        item_d.edges[r*3+c] = EdgeW'($signed(node_i[r*3+c])) - EdgeW'($signed(node_i[9+c]));
      end
    end
    for (int c = 0; c < 3; c++) begin
      sum = (CoordW+2)'($signed(node_i[c])) + (CoordW+2)'($signed(node_i[3+c]))
          + (CoordW+2)'($signed(node_i[6+c])) + (CoordW+2)'($signed(node_i[9+c]));
      item_d.cen[c] = CoordW'(sum >>> 2);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// File: src/tvs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_fifo: two-entry request queue
// Decouples the intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module tvs_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  tvs_pkg::tvs_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output tvs_pkg::tvs_item_t pop_item_o
);
  import tvs_pkg::*;

  tvs_item_t  mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_ready_i && pop_valid_o;
  assign pop_item_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

// File: src/tvs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_back: arithmetic pipeline
// Determinant, divide by six, scaling and a bit-per-stage cube root.
// ----------------------------------------------------------------------------
module tvs_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tvs_pkg::tvs_item_t               in_item_i,
  input  logic [tvs_pkg::ConstW-1:0]       inv_vol_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tvs_pkg::VolW-1:0]         tet_volume_o,
  output logic [tvs_pkg::SizeW-1:0]        size_o,
  output logic [2:0][tvs_pkg::CoordW-1:0]  cen_o
);
  import tvs_pkg::*;

  localparam int NDiv  = 7;
  localparam int SMul  = 4 + NDiv;
  localparam int NRoot = SizeW;
  localparam int NStg  = SMul + 2 + NRoot;
  localparam int NVol  = NStg - SMul;

  logic en;
  logic [NStg-1:0] vld_q;
  logic [2:0][CoordW-1:0] cen_q [NStg];

  logic signed [33:0] p_q [6], p_d [6];
  logic signed [EdgeW-1:0] ea_q [3], ea_b_q [3];
  logic signed [34:0] m_q [3], m_d [3];
  logic signed [51:0] t_q [3], t_d [3];
  logic signed [53:0] det;
  logic [53:0] mag_q, mag_d;
  logic [55:0] dx_q [NDiv], dx_d [NDiv];
  logic [55:0] dq_q [NDiv], dq_d [NDiv];
  logic [1:0]  dr_q [NDiv], dr_d [NDiv];
  logic [VolW-1:0] vol_q [NVol];
  logic [48:0] plo_q;
  logic [47:0] phi_q;
  logic [72:0] prod_q;
  logic [SizeW-1:0] rr_q [NRoot], rr_d [NRoot];
  logic [43:0] r2_q [NRoot], r2_d [NRoot];
  logic [65:0] r3_q [NRoot], r3_d [NRoot];
  logic [72:0] pr_q [NRoot], pr_d [NRoot];

  function automatic logic [9:0] div3_byte(input logic [1:0] rem, input logic [7:0] byt);
    logic [2:0] acc;
    logic [1:0] r;
    logic [7:0] q;
    r = rem;
    q = '0;
    for (int k = 7; k >= 0; k--) begin
      acc = {r, byt[k]};
      if (acc >= 3'd3) begin
        q[k] = 1'b1;
        r    = 2'(acc - 3'd3);
      end else begin
        r    = acc[1:0];
      end
    end
    return {r, q};
  endfunction

  // hold every stage while the output register is stalled
  assign en         = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o = en;

  // determinant: cofactor products, minors, triple terms, magnitude
  always_comb begin
    p_d[0] = $signed(in_item_i.edges[4]) * $signed(in_item_i.edges[8]);
    p_d[1] = $signed(in_item_i.edges[5]) * $signed(in_item_i.edges[7]);
    p_d[2] = $signed(in_item_i.edges[3]) * $signed(in_item_i.edges[8]);
    p_d[3] = $signed(in_item_i.edges[5]) * $signed(in_item_i.edges[6]);
    p_d[4] = $signed(in_item_i.edges[3]) * $signed(in_item_i.edges[7]);
    p_d[5] = $signed(in_item_i.edges[4]) * $signed(in_item_i.edges[6]);
    for (int k = 0; k < 3; k++) begin
      m_d[k] = 35'(p_q[2*k]) - 35'(p_q[2*k+1]);
      t_d[k] = ea_b_q[k] * m_q[k];
    end
    det   = 54'(t_q[0]) - 54'(t_q[1]) + 54'(t_q[2]);
    mag_d = det[53] ? 54'(-det) : 54'(det);
  end

  // divide by six: halve, then divide by three one byte a stage
  always_comb begin
    logic [9:0] st;
    for (int j = 0; j < NDiv; j++) begin
      if (j == 0) begin
        st       = div3_byte(2'd0, 8'(mag_q[53:1] >> 48));
        dx_d[j]  = {3'b0, mag_q[53:1]} << 8;
        dq_d[j]  = 56'(st[7:0]);
      end else begin
        st       = div3_byte(dr_q[j-1], dx_q[j-1][55:48]);
        dx_d[j]  = dx_q[j-1] << 8;
        dq_d[j]  = {dq_q[j-1][47:0], st[7:0]};
      end
      dr_d[j] = st[9:8];
    end
  end

  // cube root: one result bit a stage, cubes kept incrementally
  always_comb begin
    logic [SizeW-1:0] rp;
    logic [43:0] r2p;
    logic [65:0] r3p;
    logic [72:0] pp;
    logic [67:0] c3;
    int b;
    for (int i = 0; i < NRoot; i++) begin
      b = SizeW - 1 - i;
      if (i == 0) begin
        rp  = '0;
        r2p = '0;
        r3p = '0;
        pp  = prod_q;
      end else begin
        rp  = rr_q[i-1];
        r2p = r2_q[i-1];
        r3p = r3_q[i-1];
        pp  = pr_q[i-1];
      end
      c3 = 68'(r3p) + ((68'(r2p) + (68'(r2p) << 1)) << b)
         + ((68'(rp) + (68'(rp) << 1)) << (2 * b)) + (68'(1) << (3 * b));
      pr_d[i] = pp;
      if ((74'(c3) << 4) <= 74'(pp)) begin
        rr_d[i] = rp | (SizeW'(1) << b);
        r2_d[i] = 44'(46'(r2p) + (46'(rp) << (b + 1)) + (46'(1) << (2 * b)));
        r3_d[i] = c3[65:0];
      end else begin
        rr_d[i] = rp;
        r2_d[i] = r2p;
        r3_d[i] = r3p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cen_q[0] <= in_item_i.cen;
      for (int s = 1; s < NStg; s++) begin
        cen_q[s] <= cen_q[s-1];
      end
      for (int k = 0; k < 6; k++) begin
        p_q[k] <= p_d[k];
      end
      for (int k = 0; k < 3; k++) begin
        ea_q[k]   <= $signed(in_item_i.edges[k]);
        ea_b_q[k] <= ea_q[k];
        m_q[k]    <= m_d[k];
        t_q[k]    <= t_d[k];
      end
      mag_q <= mag_d;
      for (int j = 0; j < NDiv; j++) begin
        dx_q[j] <= dx_d[j];
        dq_q[j] <= dq_d[j];
        dr_q[j] <= dr_d[j];
      end
      vol_q[0] <= dq_q[NDiv-1][VolW-1:0];
      for (int v = 1; v < NVol; v++) begin
        vol_q[v] <= vol_q[v-1];
      end
      plo_q  <= 49'(dq_q[NDiv-1][24:0]) * 49'(inv_vol_i);
      phi_q  <= 48'(dq_q[NDiv-1][48:25]) * 48'(inv_vol_i);
      prod_q <= (73'(phi_q) << 25) + 73'(plo_q);
      for (int i = 0; i < NRoot; i++) begin
        rr_q[i] <= rr_d[i];
        r2_q[i] <= r2_d[i];
        r3_q[i] <= r3_d[i];
        pr_q[i] <= pr_d[i];
      end
    end
  end

  assign out_valid_o  = vld_q[NStg-1];
  assign tet_volume_o = vol_q[NVol-1];
  assign size_o       = rr_q[NRoot-1];
  assign cen_o        = cen_q[NStg-1];

endmodule

// File: src/tetra_volume_and_size.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetra_volume_and_size: tetrahedron volume, target size and centroid
// Takes four corners per request, returns volume, size and centroid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries the twelve corner
//   coordinates; output channel out_valid_o/out_ready_i carries one
//   result per request, in request order.
//   Throughput is one request per cycle while the receiver does not stall.
//   Accepted requests pass through one intake register, one queue slot and a
//   35-stage pipeline (four determinant stages, seven divide-by-three
//   stages, two scaling stages and one stage per cube-root bit).
//   A stalled receiver freezes the pipeline; the two-entry queue and
//   the intake register absorb requests until they fill, then
//   in_ready_o drops.
//   Reset empties the pipeline and loads inverse_volume_constant with
//   its default. The user must write the constant over the APB port at byte
//   address 0 while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tetra_volume_and_size (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tvs_pkg::AddrW-1:0]   paddr,
  input  logic [tvs_pkg::DataW-1:0]   pwdata,
  output logic [tvs_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [15:0]          node0_x_i,
  input  logic signed [15:0]          node0_y_i,
  input  logic signed [15:0]          node0_z_i,
  input  logic signed [15:0]          node1_x_i,
  input  logic signed [15:0]          node1_y_i,
  input  logic signed [15:0]          node1_z_i,
  input  logic signed [15:0]          node2_x_i,
  input  logic signed [15:0]          node2_y_i,
  input  logic signed [15:0]          node2_z_i,
  input  logic signed [15:0]          node3_x_i,
  input  logic signed [15:0]          node3_y_i,
  input  logic signed [15:0]          node3_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [48:0]                 tet_volume_o,
  output logic [21:0]                 tgt_size_o,
  output logic signed [15:0]          centroid_x_o,
  output logic signed [15:0]          centroid_y_o,
  output logic signed [15:0]          centroid_z_o
);
  import tvs_pkg::*;

  logic [ConstW-1:0] inv_vol_q, inv_vol_d;
  logic [11:0][CoordW-1:0] node;
  logic [2:0][CoordW-1:0] cen;
  logic fr_valid, fr_ready, bk_valid, bk_ready;
  tvs_item_t fr_item, bk_item;

  assign pready = 1'b1;

  always_comb begin
    inv_vol_d = inv_vol_q;
    if (psel && penable && pwrite && (paddr[2] == RegInvVol)) begin
      inv_vol_d = pwdata[ConstW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_vol_q <= InvVolReset;
    end else begin
      inv_vol_q <= inv_vol_d;
    end
  end

  assign prdata = (paddr[2] == RegInvVol) ? DataW'(inv_vol_q) : '0;

  assign node = {node3_z_i, node3_y_i, node3_x_i, node2_z_i, node2_y_i, node2_x_i,
                 node1_z_i, node1_y_i, node1_x_i, node0_z_i, node0_y_i, node0_x_i};

  tvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .node_i      (node),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  tvs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  tvs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (bk_valid),
    .in_ready_o    (bk_ready),
    .in_item_i     (bk_item),
    .inv_vol_i     (inv_vol_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tet_volume_o  (tet_volume_o),
    .size_o        (tgt_size_o),
    .cen_o         (cen)
  );

  assign centroid_x_o = cen[0];
  assign centroid_y_o = cen[1];
  assign centroid_z_o = cen[2];

endmodule

// File: src/tvs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_checker: port-level checks
// Watches the top-level ports of the tetrahedron volume block.
// ----------------------------------------------------------------------------
module tvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [48:0] tet_volume_o,
  input logic [21:0] tgt_size_o
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(tet_volume_o) && $stable(tgt_size_o))
    else $error("result changed while stalled");

  a_zero_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tet_volume_o == 49'd0) |-> (tgt_size_o == 22'd0))
    else $error("size without volume");

  a_reg_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[2] ##1 !paddr[2]
      |-> prdata[23:0] == $past(pwdata[23:0]))
    else $error("register readback mismatch");

endmodule

bind tetra_volume_and_size tvs_checker u_tvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .tet_volume_o  (tet_volume_o),
  .tgt_size_o    (tgt_size_o)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: tetra_volume_and_size
// Drives corner sets with bursty valid and a stalling receiver, predicts
// volume, target size and centroid for each request and compares every
// result in order. The inverse volume constant is swept over the APB port.
// ----------------------------------------------------------------------------
module testbench;
  import tvs_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int Latency = 37;

  typedef struct {
    logic [48:0] volume;
    logic [21:0] size;
    logic signed [15:0] cx, cy, cz;
  } tet_result_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o;
  logic signed [15:0] node_q [12];
  logic out_valid_o, out_ready_i = 1'b0;
  logic [48:0] tet_volume_o;
  logic [21:0] tgt_size_o;
  logic signed [15:0] centroid_x_o, centroid_y_o, centroid_z_o;

  tet_result_t expected_q[$];
  logic [ConstW-1:0] inv_vol_const = InvVolReset;
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit steady_sink = 1'b0;

  initial for (int i = 0; i < 12; i++) node_q[i] = '0;

  tetra_volume_and_size dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .node0_x_i(node_q[0]), .node0_y_i(node_q[1]), .node0_z_i(node_q[2]),
    .node1_x_i(node_q[3]), .node1_y_i(node_q[4]), .node1_z_i(node_q[5]),
    .node2_x_i(node_q[6]), .node2_y_i(node_q[7]), .node2_z_i(node_q[8]),
    .node3_x_i(node_q[9]), .node3_y_i(node_q[10]), .node3_z_i(node_q[11]),
    .out_valid_o, .out_ready_i, .tet_volume_o, .tgt_size_o,
    .centroid_x_o, .centroid_y_o, .centroid_z_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // largest n with 16*n^3 <= volume*constant
  function automatic logic [21:0] cube_root_size(logic [48:0] vol, logic [23:0] k);
    logic [127:0] target;
    logic [127:0] cube;
    logic [21:0] root;
    logic [21:0] trial;
    target = 128'(vol) * 128'(k);
    root = '0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (22'd1 << b);
      cube = 128'(trial) * 128'(trial) * 128'(trial) * 128'd16;
      if (cube <= target) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] floor_mean(logic signed [15:0] a,
      logic signed [15:0] b, logic signed [15:0] c, logic signed [15:0] d);
    logic signed [17:0] s;
    s = 18'(a) + 18'(b) + 18'(c) + 18'(d);
    return 16'(s >>> 2);
  endfunction

  function automatic tet_result_t predict_tet(logic signed [15:0] n [12]);
    logic signed [16:0] e [9];
    logic signed [63:0] det;
    logic [63:0] mag;
    tet_result_t r;
    for (int i = 0; i < 9; i++) e[i] = 17'(n[i]) - 17'(n[9 + i % 3]);
    det = 64'(e[0]) * (64'(e[4]) * e[8] - 64'(e[5]) * e[7])
        - 64'(e[1]) * (64'(e[3]) * e[8] - 64'(e[5]) * e[6])
        + 64'(e[2]) * (64'(e[3]) * e[7] - 64'(e[4]) * e[6]);
    mag = det < 0 ? 64'(-det) : 64'(det);
    r.volume = 49'(mag / 64'd6);
    r.size = cube_root_size(r.volume, inv_vol_const);
    r.cx = floor_mean(n[0], n[3], n[6], n[9]);
    r.cy = floor_mean(n[1], n[4], n[7], n[10]);
    r.cz = floor_mean(n[2], n[5], n[8], n[11]);
    return r;
  endfunction

  task automatic send_tet(logic signed [15:0] n [12]);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 12; i++) node_q[i] <= n[i];
    expected_q.insert(expected_q.size(), predict_tet(n));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    end_burst();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_inv_vol(logic [ConstW-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {RegInvVol, 2'b00}; pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    inv_vol_const = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 63)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] n [12];
    for (int i = 0; i < 12; i++) n[i] = '0;
    send_tet(n);
    // largest tetrahedron: corner three at min, edges along max
    for (int i = 0; i < 12; i++) n[i] = 16'sh8000;
    n[0] = 16'sh7fff; n[4] = 16'sh7fff; n[8] = 16'sh7fff;
    send_tet(n);
    n[0] = 16'sh8000; n[3] = 16'sh7fff;   // mirrored, negative determinant
    n[4] = 16'sh8000; n[1] = 16'sh7fff;
    send_tet(n);
    for (int i = 0; i < 12; i++) n[i] = 16'sh7fff;
    send_tet(n);
    for (int i = 0; i < 12; i++) n[i] = 16'sh8000;
    send_tet(n);
    // unit tetrahedron and a degenerate flat one
    for (int i = 0; i < 12; i++) n[i] = '0;
    n[0] = 16'sd4096; n[4] = 16'sd4096; n[8] = 16'sd4096;
    send_tet(n);
    n[8] = '0;
    send_tet(n);
    for (int i = 0; i < 12; i++) n[i] = (i % 2) ? -16'sd1 : 16'sd1;
    send_tet(n);
    drain();
  endtask

  task automatic test_constants();
    logic [ConstW-1:0] ks [5] = '{24'd1, 24'hffffff, 24'd65536, 24'd0, InvVolReset};
    logic signed [15:0] n [12];
    foreach (ks[j]) begin
      write_inv_vol(ks[j]);
      for (int t = 0; t < 15; t++) begin
        for (int i = 0; i < 12; i++) n[i] = rand_coord();
        if (t == 0) begin
          for (int i = 0; i < 12; i++) n[i] = 16'sh8000;
          n[0] = 16'sh7fff; n[4] = 16'sh7fff; n[8] = 16'sh7fff;
        end
        send_tet(n);
      end
      drain();
    end
  endtask

  task automatic test_random();
    logic signed [15:0] n [12];
    for (int t = 0; t < 1000; t++) begin
      if (t == 400) write_inv_vol(24'($urandom_range(1, 24'hffffff)));
      for (int i = 0; i < 12; i++) n[i] = rand_coord();
      send_tet(n);
      if (t == 399) drain();
    end
    drain();
  endtask

  task automatic test_backpressure();
    logic signed [15:0] n [12];
    hold_off = 1'b1;
    for (int t = 0; t < 60; t++) begin
      for (int i = 0; i < 12; i++) n[i] = rand_coord();
      send_tet(n);
    end
    drain();
  endtask

  // receiver: long hold-off on request, else random stalls with calm stretches
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 99) == 0) steady_sink = ~steady_sink;
      out_ready_i <= steady_sink || ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk_i) begin
    tet_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, volume %0d", $time, tet_volume_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (tet_volume_o !== exp_r.volume) begin
          $display("%0t: tet_volume expected %0d actual %0d", $time, exp_r.volume,
                   tet_volume_o);
          errors++;
        end
        if (tgt_size_o !== exp_r.size) begin
          $display("%0t: tgt_size expected %0d actual %0d", $time, exp_r.size,
                   tgt_size_o);
          errors++;
        end
        if (centroid_x_o !== exp_r.cx) begin
          $display("%0t: centroid_x expected %0d actual %0d", $time, exp_r.cx,
                   centroid_x_o);
          errors++;
        end
        if (centroid_y_o !== exp_r.cy) begin
          $display("%0t: centroid_y expected %0d actual %0d", $time, exp_r.cy,
                   centroid_y_o);
          errors++;
        end
        if (centroid_z_o !== exp_r.cz) begin
          $display("%0t: centroid_z expected %0d actual %0d", $time, exp_r.cz,
                   centroid_z_o);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles with no request, result or APB access moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_constants();
    test_random();
    test_backpressure();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
